### hdl/hwrms_pkg.sv
// Shared constants, types and the Hann coefficient function for the RMS level meter.
`default_nettype none
package hwrms_pkg;

    // Window geometry
    localparam int HW_WIN  = 1024;
    localparam int HW_AW   = $clog2(HW_WIN);
    localparam int HW_SPAN = HW_WIN - 1;
    localparam logic [63:0] HW_DEN = 64'(HW_SPAN) << 30;

    // Field widths
    localparam int HW_SW  = 16;
    localparam int HW_LW  = 15;
    localparam int HW_IW  = 11;
    localparam int HW_ACW = 58;

    // Fixed-point constants
    localparam logic [63:0] HW_PI_Q30  = 64'd3373259426;
    localparam logic [63:0] HW_ONE_Q30 = 64'd1073741824;
    localparam logic signed [26:0] HW_DB_K = 27'sd50504453;
    // 25600 * 2^32 + 2^31: offset to 100 dB plus rounding half
    localparam logic signed [50:0] HW_PBIAS = 51'sh6400_8000_0000;
    localparam logic [HW_IW-1:0] HW_INTV_RST = HW_IW'(512);

    typedef logic [HW_SW-1:0] t_sample;
    typedef logic [HW_LW-1:0] t_level;

    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 30;
    endfunction

    // sin in Q30 by a ninth-order Taylor polynomial, Horner form
    function automatic logic [63:0] sin_q30(input logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] h;
        t2 = mul_q30(t, t);
        h  = HW_ONE_Q30 - t2 / 72;
        h  = HW_ONE_Q30 - mul_q30(t2 / 42, h);
        h  = HW_ONE_Q30 - mul_q30(t2 / 20, h);
        h  = HW_ONE_Q30 - mul_q30(t2 / 6, h);
        return mul_q30(t, h);
    endfunction

    // Hann weight, unsigned Q0.16, normalised to sum one
    function automatic logic [15:0] hann_coef(input int i);
        logic [63:0] j;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] s2;
        logic [63:0] c;
        j  = (i <= HW_SPAN - i) ? 64'(i) : 64'(HW_SPAN - i);
        t  = (HW_PI_Q30 * j) / HW_SPAN;
        s  = sin_q30(t);
        s2 = mul_q30(s, s);
        c  = ((s2 << 17) + (HW_DEN >> 1)) / HW_DEN;
        return (c > 64'd65535) ? 16'hFFFF : c[15:0];
    endfunction

endpackage
`default_nettype wire

### hdl/hwrms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module hwrms_ram
    import hwrms_pkg::*;
#(
    parameter int WIDTH = HW_SW,
    parameter int DEPTH = HW_WIN
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### hdl/hann_window_rms_level_db_top.sv
// Top level of the Hann-windowed RMS level meter with dB output.
//
//  Channel  | Dir | Handshake                     | Payload
//  ---------+-----+-------------------------------+---------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata[15:0] sample (Q1.15)
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata[14:0] level_db, [15] zero
//  cfg      | in  | i_cfg_wen                     | i_cfg_wdata[10:0] window_interval
//
//  A sample that does not complete an interval leaves the sequencer idle for the next sample.
//  A reporting sample runs the MAC over all HW_WIN ring entries (one ring read per cycle),
//  up to 58 normalise steps, 16 log2 squaring steps and the scaling states XSUB, MULK and FIN.
//  The ring needs no clearing pass: a fill count makes unwritten entries read as zero.
//  A result waits in the output register; samples keep being taken meanwhile, and
//  a further report holds in its final state until that register is free.
`default_nettype none
module hann_window_rms_level_db_top
    import hwrms_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [15:0]      s_axis_tdata,   // [15:0] sample
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic      [15:0]      m_axis_tdata,   // [14:0] level_db, [15] zero pad
    input  wire logic             i_cfg_wen,
    input  wire logic [HW_IW-1:0] i_cfg_wdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_NORM  = 3'd3;
    localparam logic [2:0] ST_LOG   = 3'd4;
    localparam logic [2:0] ST_XSUB  = 3'd5;
    localparam logic [2:0] ST_MULK  = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    localparam logic [HW_AW-1:0] LAST_POS = HW_AW'(HW_WIN - 1);

    logic [2:0]        r_state, n_state;
    logic [HW_AW-1:0]  r_wp;
    logic [HW_AW:0]    r_fill;
    logic [HW_IW-1:0]  r_cnt;
    logic [HW_IW-1:0]  r_intv;
    logic [HW_AW-1:0]  r_k;
    logic [HW_AW-1:0]  r_rd;
    logic              r_iss, r_ok, r_v2, r_v3;
    logic              r_ovalid;
    logic              r_zero;
    logic [15:0]       r_coef_q, r_coef2;
    logic [30:0]       r_sq;
    logic [46:0]       r_prod;
    logic [HW_ACW-1:0] r_acc;
    logic [5:0]        r_e;
    logic [30:0]       r_m;
    logic [3:0]        r_b;
    logic [15:0]       r_frac;
    logic signed [23:0] r_x;
    logic signed [50:0] r_p;
    t_level            r_level;

    logic [15:0]       w_coef [HW_WIN];
    t_sample           w_ram_q;
    logic              w_in_acc;
    logic [HW_AW-1:0]  w_wp1;
    logic [HW_IW-1:0]  w_cnt1, w_lim;
    logic              w_report;
    logic [15:0]       w_mag;
    logic [61:0]       w_sqm;
    logic [31:0]       w_m2;
    logic signed [50:0] w_pb;
    logic [18:0]       w_lv;
    t_level            w_level;

    // Hann coefficient ROM, one constant per entry
    for (genvar g = 0; g < HW_WIN; g++) begin : g_coef
        assign w_coef[g] = hann_coef(g);
    end

    // Sample ring
    hwrms_ram #(
        .WIDTH (HW_SW),
        .DEPTH (HW_WIN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_in_acc),
        .i_waddr (r_wp),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_rd),
        .o_rdata (w_ram_q)
    );

    // Input side and interval counting
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_wp1         = (r_wp == LAST_POS) ? '0 : r_wp + 1'b1;
    assign w_cnt1        = r_cnt + 1'b1;
    assign w_lim         = (r_intv == '0) ? HW_IW'(1) : r_intv;
    assign w_report      = (w_cnt1 >= w_lim);

    // Datapath helpers: magnitude, log2 squaring, final scaling
    assign w_mag   = w_ram_q[15] ? (~w_ram_q + 16'd1) : w_ram_q;
    assign w_sqm   = r_m * r_m;
    assign w_m2    = w_sqm[61:30];
    assign w_pb    = r_p + HW_PBIAS;
    assign w_lv    = w_pb[50:32];
    assign w_level = (r_zero || w_pb[50]) ? '0 :
                     (w_lv > 19'd32767)   ? HW_LW'(32767) : w_lv[14:0];

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_acc && w_report) n_state = ST_MAC;
            ST_MAC:   if (r_k == LAST_POS) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_iss && !r_v2 && !r_v3) n_state = ST_NORM;
            ST_NORM:  if (r_acc == '0) begin
                          n_state = ST_FIN;
                      end else if (r_acc[HW_ACW-1]) begin
                          n_state = ST_LOG;
                      end
            ST_LOG:   if (r_b == 4'd0) n_state = ST_XSUB;
            ST_XSUB:  n_state = ST_MULK;
            ST_MULK:  n_state = ST_FIN;
            ST_FIN:   if (!r_ovalid) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wp     <= '0;
            r_fill   <= '0;
            r_cnt    <= '0;
            r_intv   <= HW_INTV_RST;
            r_iss    <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iss   <= (r_state == ST_MAC);
            r_v2    <= r_iss;
            r_v3    <= r_v2;
            if (i_cfg_wen) begin
                r_intv <= i_cfg_wdata;
            end
            // Store sample and advance ring position
            if (w_in_acc) begin
                r_wp  <= w_wp1;
                r_cnt <= w_report ? '0 : w_cnt1;
                if (!r_fill[HW_AW]) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            // Hold result until the downstream takes it
            if (r_state == ST_FIN && !r_ovalid) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // MAC pipeline, normalise, log2 and scaling
    always_ff @(posedge i_clk) begin
        r_coef_q <= w_coef[r_k];
        r_ok     <= r_fill[HW_AW] || ({1'b0, r_rd} < r_fill);
        r_sq     <= r_ok ? 31'({15'd0, w_mag} * {15'd0, w_mag}) : '0;
        r_coef2  <= r_coef_q;
        r_prod   <= {16'd0, r_sq} * {31'd0, r_coef2};
        if (r_v3) begin
            r_acc <= r_acc + HW_ACW'(r_prod);
        end
        unique case (r_state)
            ST_IDLE: begin
                r_k   <= '0;
                r_rd  <= w_wp1;
                r_acc <= '0;
            end
            ST_MAC: begin
                r_k  <= r_k + 1'b1;
                r_rd <= (r_rd == LAST_POS) ? '0 : r_rd + 1'b1;
            end
            ST_DRAIN: begin
                r_e    <= 6'(HW_ACW - 1);
                r_zero <= 1'b0;
            end
            ST_NORM: begin
                if (r_acc == '0) begin
                    r_zero <= 1'b1;
                end else if (r_acc[HW_ACW-1]) begin
                    r_m    <= r_acc[HW_ACW-1 -: 31];
                    r_b    <= 4'd15;
                    r_frac <= '0;
                end else begin
                    r_acc <= r_acc << 1;
                    r_e   <= r_e - 1'b1;
                end
            end
            ST_LOG: begin
                r_frac[r_b] <= w_m2[31];
                r_m         <= w_m2[31] ? w_m2[31:1] : w_m2[30:0];
                r_b         <= r_b - 1'b1;
            end
            ST_XSUB: begin
                r_x <= $signed({2'b00, r_e, r_frac}) - 24'sd3014656;
            end
            ST_MULK: begin
                r_p <= 51'(r_x) * 51'(HW_DB_K);
            end
            ST_FIN: begin
                if (!r_ovalid) begin
                    r_level <= w_level;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_level};

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (HW_AW+1)'(HW_WIN))
        else $error("fill count beyond window");
    a_norm_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NORM) |-> (!r_iss && !r_v2 && !r_v3))
        else $error("normalise entered with MAC pipeline busy");
    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOG) |-> r_m[30])
        else $error("log2 mantissa not normalised");
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_FIN))
        else $error("result raised outside final state");

endmodule
`default_nettype wire

### test/hwrms_checker.sv
// Checker for the RMS level meter: watches the streams, predicts levels and compares them.
`default_nettype none
module hwrms_checker
    import hwrms_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [15:0] i_in_data,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [15:0] i_out_data,
    input  wire logic        i_cfg_wen,
    input  wire logic [10:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_samples_seen,
    output int               o_levels_seen
);

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] Q30_PI  = 64'd3373259426;
    localparam longint      DB_K    = 64'sd50504453;

    logic [15:0] recent_samples [HW_WIN];
    logic [15:0] hann_weight [HW_WIN];
    int          ring_wr;
    logic [10:0] interval_count;
    logic [10:0] interval_reg;
    t_level      expected_levels [$];

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    // Taylor sine in Q30 for the folded angle
    function automatic logic [63:0] qsin(input logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] h;
        t2 = qmul(t, t);
        h  = Q30_ONE - t2 / 72;
        h  = Q30_ONE - qmul(t2 / 42, h);
        h  = Q30_ONE - qmul(t2 / 20, h);
        h  = Q30_ONE - qmul(t2 / 6, h);
        return qmul(t, h);
    endfunction

    // Integer part from the top set bit, fraction by repeated squaring
    function automatic longint log2_q16(input logic [63:0] v);
        int          e;
        logic [63:0] m;
        longint      frac;
        e    = 0;
        frac = 0;
        while (e < 63 && (v >> (e + 1)) != 0) e++;
        m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
        for (int b = 15; b >= 0; b--) begin
            m = qmul(m, m);
            if (m >= (Q30_ONE << 1)) begin
                frac |= longint'(1) << b;
                m = m >> 1;
            end
        end
        return longint'(e) * 65536 + frac;
    endfunction

    function automatic t_level level_for_energy(input logic [63:0] s);
        longint x;
        longint p;
        if (s == 0) return '0;
        x = log2_q16(s) - longint'(46) * 65536;
        p = x * DB_K + 64'sd2147483648 + 64'sd25600 * 64'sd4294967296;
        if (p < 0) return '0;
        p = p >>> 32;
        return (p > 32767) ? 15'h7FFF : t_level'(p);
    endfunction

    // Weighted energy over the ring, oldest sample first
    function automatic logic [63:0] windowed_energy();
        logic [63:0] acc;
        logic [31:0] mag;
        int          pos;
        acc = 0;
        pos = ring_wr;
        for (int k = 0; k < HW_WIN; k++) begin
            mag = recent_samples[pos][15] ? 32'(32'd65536 - recent_samples[pos])
                                          : 32'(recent_samples[pos]);
            acc += 64'(mag) * 64'(mag) * 64'(hann_weight[k]);
            pos = (pos + 1 >= HW_WIN) ? 0 : pos + 1;
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        o_fail_count++;
    endtask

    // Build the Hann table once
    initial begin
        logic [63:0] j;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] c;
        for (int i = 0; i < HW_WIN; i++) begin
            j = (i <= HW_WIN - 1 - i) ? 64'(i) : 64'(HW_WIN - 1 - i);
            t = (Q30_PI * j) / (HW_WIN - 1);
            s = qmul(qsin(t), qsin(t));
            c = ((s << 17) + ((64'(HW_WIN - 1) << 30) >> 1)) / (64'(HW_WIN - 1) << 30);
            hann_weight[i] = (c > 65535) ? 16'hFFFF : c[15:0];
        end
    end

    initial begin
        o_fail_count   = 0;
        o_samples_seen = 0;
        o_levels_seen  = 0;
    end

    assign o_pending = expected_levels.size();

    always @(posedge i_clk) begin
        logic [10:0] limit;
        t_level      want;
        if (!i_rst_n) begin
            for (int i = 0; i < HW_WIN; i++) recent_samples[i] = '0;
            ring_wr        = 0;
            interval_count = '0;
            interval_reg   = HW_INTV_RST;
        end else begin
            // Register write
            if (i_cfg_wen) interval_reg = i_cfg_wdata;
            // Predict on each accepted sample transaction
            if (i_in_valid && i_in_ready) begin
                o_samples_seen++;
                recent_samples[ring_wr] = i_in_data;
                ring_wr        = (ring_wr + 1 >= HW_WIN) ? 0 : ring_wr + 1;
                limit          = (interval_reg == 0) ? 11'd1 : interval_reg;
                interval_count = interval_count + 11'd1;
                if (interval_count >= limit) begin
                    interval_count = '0;
                    expected_levels.push_back(level_for_energy(windowed_energy()));
                end
            end
            // Compare each level transaction with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                o_levels_seen++;
                if (expected_levels.size() == 0) begin
                    report_mismatch($sformatf("unexpected level %0d", i_out_data[14:0]));
                end else begin
                    want = expected_levels.pop_front();
                    if (i_out_data[14:0] !== want)
                        report_mismatch($sformatf("level %0d, expected %0d",
                                                  i_out_data[14:0], want));
                    if (i_out_data[15] !== 1'b0)
                        report_mismatch("pad bit of level not zero");
                end
            end
        end
    end

endmodule
`default_nettype wire

### test/tb.sv
// Testbench top for the RMS level meter: stimulus, idling, pressure and verdict.
`default_nettype none
module tb;

    localparam int DRAIN_CYCLES = 1300;
    localparam int HOLD_CYCLES  = 5000;
    localparam int CYCLE_LIMIT  = 10000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] in_data;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] out_data;
    logic        cfg_wen;
    logic [10:0] cfg_wdata;
    int          fail_count;
    int          pending;
    int          samples_seen;
    int          levels_seen;
    int          sender_idle;
    int          receiver_idle;
    int          items_sent;
    bit          hold_request;
    int          cycle_count;

    hann_window_rms_level_db_top i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data),
        .i_cfg_wen     (cfg_wen),
        .i_cfg_wdata   (cfg_wdata)
    );

    hwrms_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .i_cfg_wen      (cfg_wen),
        .i_cfg_wdata    (cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_samples_seen (samples_seen),
        .o_levels_seen  (levels_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort on a runaway run
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Level receiver: random back-pressure, plus one long hold-off on request
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    // Pick idling by progress: slow receiver first, then slow sender, then none
    function automatic void set_idling();
        if (items_sent < 650) begin
            sender_idle   = 23;
            receiver_idle = 87;
        end else if (items_sent < 1300) begin
            sender_idle   = 87;
            receiver_idle = 23;
        end else begin
            sender_idle   = 0;
            receiver_idle = 0;
        end
    endfunction

    task automatic send_sample(input logic [15:0] s);
        set_idling();
        @(negedge clk);
        while ($urandom_range(99) < sender_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    function automatic logic [15:0] random_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5) return 16'($urandom);
        if (pick < 8) return 16'($signed($urandom_range(400)) - 200);
        return pick[0] ? 16'h8000 : 16'h7FFF;
    endfunction

    task automatic send_random(input int n);
        repeat (n) send_sample(random_sample());
    endtask

    // Drop valid, let every level drain and the MAC settle, then write the interval
    task automatic write_interval(input logic [10:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_wen   <= 1'b0;
    endtask

    initial begin
        logic [15:0] directed [20];
        directed = '{16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'h0000, 16'h8000,
                     16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001, 16'h5555,
                     16'hAAAA, 16'h00FF, 16'hFF00, 16'h4000, 16'hC000, 16'h8001,
                     16'h7FFE, 16'h0000};
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_wen      = 1'b0;
        cfg_wdata    = '0;
        items_sent   = 0;
        hold_request = 1'b0;
        set_idling();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Report on every sample: silence, tiny levels, full scale
        write_interval(11'd1);
        foreach (directed[i]) send_sample(directed[i]);
        // Zero interval acts as one
        write_interval(11'd0);
        send_random(10);
        // Short interval under a long output stall
        write_interval(11'd13);
        hold_request = 1'b1;
        send_random(300);
        write_interval(11'd512);
        send_random(550);
        write_interval(11'd1024);
        send_random(1030);
        // Largest interval, then lower it under the running count
        write_interval(11'd2047);
        send_random(20);
        write_interval(11'd5);
        send_random(30);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d samples and %0d level reports", samples_seen, levels_seen);
        $display("intervals 1, 0, 13, 512, 1024, 2047 and 5, with a long output hold-off");
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
hdl/hwrms_pkg.sv
hdl/hwrms_ram.sv
hdl/hann_window_rms_level_db_top.sv
test/hwrms_checker.sv
test/tb.sv
